### rtl/fca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Full-circle arctangent: shared types, constants and arctangent table
// Word formats for the request and response channels, the word handed
// between CORDIC cells, and the per-stage rotation angles.
// ----------------------------------------------------------------------------
package fca_pkg;

   // Field widths of the request and response words
   localparam int COORD_WIDTH = 16;
   localparam int ANGLE_WIDTH = 16;

   // Default and largest number of CORDIC cells
   localparam int ITERATIONS_DEFAULT = 16;
   localparam int ITERATIONS_MAX     = 32;

   // Datapath: magnitude plus guard bits, headroom for CORDIC gain, sign
   localparam int GUARD_BITS = 8;
   localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS + 2;

   // Angle accumulator in units of 2^-32 turn, signed with headroom
   localparam int TURN_WIDTH = 32;
   localparam int Z_WIDTH    = TURN_WIDTH + 2;
   localparam int IDX_WIDTH  = $clog2(ITERATIONS_MAX);

   // Binary angles for a quarter (pi/2) and a half (pi) turn; a full turn
   // (2 pi) is the wrap of a TURN_WIDTH-bit word
   localparam logic [TURN_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [TURN_WIDTH-1:0] HALF_TURN    = 32'h8000_0000;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] y_coord;
      logic signed [COORD_WIDTH-1:0] x_coord;
   } req_type;

   typedef struct packed {
      logic [ANGLE_WIDTH-1:0] angle;
      logic                   at_origin;
   } rsp_type;

   // Quadrant and axis flags carried alongside the rotation
   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic x_zero;
      logic y_zero;
   } side_type;

   // Word handed from cell to cell
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] cx;
      logic signed [DATA_WIDTH-1:0] cy;
      logic signed [Z_WIDTH-1:0]    z;
      side_type                     side;
   } cordic_type;

   // atan(2^-i) / (2 pi) * 2^32, rounded
   function automatic logic [TURN_WIDTH-1:0] atan_entry(input logic [IDX_WIDTH-1:0] idx);
      logic [TURN_WIDTH-1:0] val;
      unique case (idx)
         5'd0:  val = 32'h2000_0000;
         5'd1:  val = 32'h12E4_051E;
         5'd2:  val = 32'h09FB_385B;
         5'd3:  val = 32'h0511_11D4;
         5'd4:  val = 32'h028B_0D43;
         5'd5:  val = 32'h0145_D7E1;
         5'd6:  val = 32'h00A2_F61E;
         5'd7:  val = 32'h0051_7C55;
         5'd8:  val = 32'h0028_BE53;
         5'd9:  val = 32'h0014_5F2F;
         5'd10: val = 32'h000A_2F98;
         5'd11: val = 32'h0005_17CC;
         5'd12: val = 32'h0002_8BE6;
         5'd13: val = 32'h0001_45F3;
         5'd14: val = 32'h0000_A2FA;
         5'd15: val = 32'h0000_517D;
         5'd16: val = 32'h0000_28BE;
         5'd17: val = 32'h0000_145F;
         5'd18: val = 32'h0000_0A30;
         5'd19: val = 32'h0000_0518;
         5'd20: val = 32'h0000_028C;
         5'd21: val = 32'h0000_0146;
         5'd22: val = 32'h0000_00A3;
         5'd23: val = 32'h0000_0051;
         5'd24: val = 32'h0000_0029;
         5'd25: val = 32'h0000_0014;
         5'd26: val = 32'h0000_000A;
         5'd27: val = 32'h0000_0005;
         5'd28: val = 32'h0000_0003;
         5'd29: val = 32'h0000_0001;
         5'd30: val = 32'h0000_0001;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

### rtl/fca_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Full-circle arctangent: input stage
// Takes magnitudes of both coordinates, scales them into the datapath and
// records the quadrant and axis flags.
// ----------------------------------------------------------------------------
module fca_prep import fca_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  req_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output cordic_type out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   cordic_type           data_ff;
   cordic_type           data_in;
   logic [COORD_WIDTH:0] ext_x;
   logic [COORD_WIDTH:0] ext_y;
   logic [COORD_WIDTH:0] mag_x;
   logic [COORD_WIDTH:0] mag_y;

   assign in_ready = !valid_ff || out_ready;

   // Form magnitudes and flags
   always_comb begin
      ext_x = {in_data.x_coord[COORD_WIDTH-1], in_data.x_coord};
      ext_y = {in_data.y_coord[COORD_WIDTH-1], in_data.y_coord};
      mag_x = ext_x[COORD_WIDTH] ? (~ext_x + 1'b1) : ext_x;
      mag_y = ext_y[COORD_WIDTH] ? (~ext_y + 1'b1) : ext_y;
      data_in.cx          = $signed({1'b0, mag_x, {GUARD_BITS{1'b0}}});
      data_in.cy          = $signed({1'b0, mag_y, {GUARD_BITS{1'b0}}});
      data_in.z           = '0;
      data_in.side.x_neg  = in_data.x_coord[COORD_WIDTH-1];
      data_in.side.y_neg  = in_data.y_coord[COORD_WIDTH-1];
      data_in.side.x_zero = (in_data.x_coord == '0);
      data_in.side.y_zero = (in_data.y_coord == '0);
      valid_in            = in_ready ? in_valid : valid_ff;
   end

   // Hold valid under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the word when taken
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/fca_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Full-circle arctangent: CORDIC vectoring cell
// One micro-rotation towards the x-axis with a fixed shift of STAGE, and
// the matching angle step added to or taken from the accumulator.
// ----------------------------------------------------------------------------
module fca_cell import fca_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  cordic_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output cordic_type out_data
);

   logic                         valid_ff;
   logic                         valid_in;
   cordic_type                   data_ff;
   cordic_type                   data_in;
   logic signed [DATA_WIDTH-1:0] dx;
   logic signed [DATA_WIDTH-1:0] dy;
   logic signed [Z_WIDTH-1:0]    step_angle;

   assign in_ready = !valid_ff || out_ready;

   // Rotate by the sign of y
   always_comb begin
      dx         = in_data.cy >>> STAGE;
      dy         = in_data.cx >>> STAGE;
      step_angle = $signed({{(Z_WIDTH-TURN_WIDTH){1'b0}},
                            atan_entry(IDX_WIDTH'(STAGE))});
      data_in    = in_data;
      if (!in_data.cy[DATA_WIDTH-1]) begin
         data_in.cx = in_data.cx + dx;
         data_in.cy = in_data.cy - dy;
         data_in.z  = in_data.z + step_angle;
      end else begin
         data_in.cx = in_data.cx - dx;
         data_in.cy = in_data.cy + dy;
         data_in.z  = in_data.z - step_angle;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   // Hold valid under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Advance the word
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/fca_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Full-circle arctangent: quadrant fold and output register
// Clamps the first-quadrant angle, applies the axis cases, folds into the
// quadrant and rounds to the output width.
// ----------------------------------------------------------------------------
module fca_fold import fca_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  cordic_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_data
);

   localparam int ROUND_SHIFT = TURN_WIDTH - ANGLE_WIDTH;
   localparam logic [TURN_WIDTH-1:0] ROUND_HALF =
      TURN_WIDTH'((64'(1) << ROUND_SHIFT) >> 1);

   logic                  valid_ff;
   logic                  valid_in;
   rsp_type               data_ff;
   rsp_type               data_in;
   logic [TURN_WIDTH-1:0] clamped;
   logic [TURN_WIDTH-1:0] first_angle;
   logic [TURN_WIDTH-1:0] phi;
   logic [TURN_WIDTH-1:0] rounded;
   logic                  origin;

   assign in_ready = !valid_ff || out_ready;

   // Clamp, fold and round
   always_comb begin
      priority if (in_data.z[Z_WIDTH-1]) begin
         clamped = '0;
      end else if (in_data.z > $signed({{(Z_WIDTH-TURN_WIDTH){1'b0}}, QUARTER_TURN})) begin
         clamped = QUARTER_TURN;
      end else begin
         clamped = in_data.z[TURN_WIDTH-1:0];
      end

      priority if (in_data.side.x_zero) begin
         first_angle = QUARTER_TURN;
      end else if (in_data.side.y_zero) begin
         first_angle = '0;
      end else begin
         first_angle = clamped;
      end

      unique case ({in_data.side.x_neg, in_data.side.y_neg})
         2'b00:   phi = first_angle;
         2'b10:   phi = HALF_TURN - first_angle;
         2'b11:   phi = HALF_TURN + first_angle;
         default: phi = '0 - first_angle;
      endcase

      rounded = phi + ROUND_HALF;
      origin  = in_data.side.x_zero && in_data.side.y_zero;

      data_in.at_origin = origin;
      data_in.angle     = origin ? '0 : rounded[TURN_WIDTH-1 -: ANGLE_WIDTH];
      valid_in          = in_ready ? in_valid : valid_ff;
   end

   // Hold valid under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the response word
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/full_circle_arctangent_unit.sv
`timescale 1ns / 1ps
// Registers from request to response: one input stage, one CORDIC cell per
// iteration, one fold/output stage.
// Throughput: one word per cycle while rsp_ready is high; a stage stalls
// only when full and the next stage cannot take its word: bubbles close up.
// Reset clears the valid bit of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
// Full-circle arctangent unit
// Angle of (x, y) over the full turn as a binary angle, from a chain of
// CORDIC vectoring cells on the coordinate magnitudes.
// ----------------------------------------------------------------------------
module full_circle_arctangent_unit import fca_pkg::*; #(
   parameter int ITERATIONS = ITERATIONS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       link_valid [ITERATIONS+1];
   logic       link_ready [ITERATIONS+1];
   cordic_type link_data  [ITERATIONS+1];

   // Scale magnitudes and capture flags
   fca_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // Chain of vectoring cells
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
      fca_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // Fold into the quadrant and drive the response
   fca_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[ITERATIONS]),
      .in_ready  (link_ready[ITERATIONS]),
      .in_data   (link_data[ITERATIONS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

### bench/full_circle_arctangent_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Full-circle arctangent unit: self-checking testbench
// Runs a short table of axis, origin and extreme vectors, then some 1800
// random vectors, through the unit. Both channels idle and stall at random.
// Every response word is checked, field by field, against its typed table
// answer or a bit-exact fixed-point CORDIC predictor run with the request side.
// ----------------------------------------------------------------------------
module full_circle_arctangent_unit_tb;
   import fca_pkg::*;

   // Predictor set-up (CORDIC depth, guard bits, turn constants) and run sizes
   localparam int     CELLS       = ITERATIONS_DEFAULT;
   localparam int     SCALE_SHIFT = 8;
   localparam int     DROP        = 32 - ANGLE_WIDTH;
   localparam longint QUARTER     = 64'sh4000_0000;
   localparam longint HALF        = 64'sh8000_0000;
   localparam longint FULL        = 64'sh1_0000_0000;
   localparam int     RANDOM_WORDS = 1800;
   localparam int     PROBES      = 21;

   // One row of the directed table; typed rows carry their own answer
   typedef struct {
      logic [COORD_WIDTH-1:0] y;
      logic [COORD_WIDTH-1:0] x;
      bit                     typed;
      logic [ANGLE_WIDTH-1:0] angle;
      logic                   origin;
   } probe_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type pending_bearings[$];
   int      bearing_errors;

   // atan(2^-i) in units of 2^-32 turn
   longint rot_angle [32] = '{
      64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
      64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
      64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
      64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D,
      64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
      64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051,
      64'h0000_0029, 64'h0000_0014, 64'h0000_000A, 64'h0000_0005,
      64'h0000_0003, 64'h0000_0001, 64'h0000_0001, 64'h0000_0000
   };

   // Origin, the four half-axes, corners and bit patterns
   probe_row_type probe_table [PROBES] = '{
      '{16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1},
      '{16'h0000, 16'h0001, 1'b1, 16'h0000, 1'b0},
      '{16'h0000, 16'h7FFF, 1'b1, 16'h0000, 1'b0},
      '{16'h0000, 16'hFFFF, 1'b1, 16'h8000, 1'b0},
      '{16'h0000, 16'h8000, 1'b1, 16'h8000, 1'b0},
      '{16'h0001, 16'h0000, 1'b1, 16'h4000, 1'b0},
      '{16'h7FFF, 16'h0000, 1'b1, 16'h4000, 1'b0},
      '{16'hFFFF, 16'h0000, 1'b1, 16'hC000, 1'b0},
      '{16'h8000, 16'h0000, 1'b1, 16'hC000, 1'b0},
      '{16'h0001, 16'h0001, 1'b0, 16'h0000, 1'b0},
      '{16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{16'h8000, 16'h8000, 1'b0, 16'h0000, 1'b0},
      '{16'h7FFF, 16'h8000, 1'b0, 16'h0000, 1'b0},
      '{16'h8000, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{16'h0001, 16'h8000, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 16'h8000, 1'b0, 16'h0000, 1'b0},
      '{16'h7FFF, 16'h0001, 1'b0, 16'h0000, 1'b0},
      '{16'h8000, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{16'h5555, 16'hAAAA, 1'b0, 16'h0000, 1'b0},
      '{16'hAAAA, 16'h5555, 1'b0, 16'h0000, 1'b0}
   };

   full_circle_arctangent_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Expected bearing of one vector: CORDIC on the magnitudes, then fold
   function automatic rsp_type predict_bearing(input req_type word);
      longint  y, x, mag_x, mag_y, cx, cy, z, dx, dy, quad, phi;
      rsp_type bearing;
      y = longint'($signed(word.y_coord));
      x = longint'($signed(word.x_coord));
      bearing = '0;
      if (x == 0 && y == 0) begin
         bearing.at_origin = 1'b1;
         return bearing;
      end
      mag_x = (x < 0) ? -x : x;
      mag_y = (y < 0) ? -y : y;
      if (x == 0) begin
         quad = QUARTER;
      end else if (y == 0) begin
         quad = 0;
      end else begin
         cx = mag_x <<< SCALE_SHIFT;
         cy = mag_y <<< SCALE_SHIFT;
         z  = 0;
         // rotate towards the x-axis, steering on the sign of y
         for (int i = 0; i < CELLS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
               cx = cx + dx;
               cy = cy - dy;
               z  = z + rot_angle[i];
            end else begin
               cx = cx - dx;
               cy = cy + dy;
               z  = z - rot_angle[i];
            end
         end
         if (z < 0) z = 0;
         if (z > QUARTER) z = QUARTER;
         quad = z;
      end
      // fold into the quadrant, wrap to one turn, round to the output width
      if (x >= 0 && y >= 0) phi = quad;
      else if (x < 0 && y >= 0) phi = HALF - quad;
      else if (x < 0) phi = HALF + quad;
      else phi = FULL - quad;
      phi = phi & 64'h0000_0000_FFFF_FFFF;
      if (DROP > 0) phi = phi + (64'sd1 <<< (DROP - 1));
      bearing.angle = phi[DROP +: ANGLE_WIDTH];
      return bearing;
   endfunction

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [COORD_WIDTH-1:0] extreme_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h8001;
         2: return 16'hFFFF;
         3: return 16'h0000;
         4: return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   // Random vector: mostly full range, with small, axis, extreme and
   // near-diagonal vectors mixed in
   function automatic req_type random_word();
      req_type word;
      word = req_type'($urandom);
      case ($urandom_range(0, 9))
         5, 6: begin
            word.y_coord = COORD_WIDTH'($urandom_range(0, 16)) - 16'd8;
            word.x_coord = COORD_WIDTH'($urandom_range(0, 16)) - 16'd8;
         end
         7: begin
            if ($urandom_range(0, 1)) word.y_coord = '0;
            else word.x_coord = '0;
         end
         8: begin
            word.y_coord = extreme_coord();
            word.x_coord = extreme_coord();
         end
         9: begin
            word.y_coord = word.x_coord + COORD_WIDTH'($urandom_range(0, 6)) - 16'd3;
            if ($urandom_range(0, 1)) word.y_coord = -word.y_coord;
         end
         default: ;
      endcase
      return word;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      bearing_errors++;
   endtask

   // Offer one word, hold it until taken, then queue its expected bearing
   task automatic send_word(input req_type word, input bit typed, input rsp_type answer);
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      if (typed) pending_bearings.push_back(answer);
      else pending_bearings.push_back(predict_bearing(word));
      @(negedge clock);
   endtask

   // Drop valid for a random gap, with occasional back-to-back bursts
   task automatic idle_source(inout int burst_left);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(20, 60);
         gap = 0;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Check each accepted response word against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bearings.size() == 0) begin
            report_mismatch($sformatf("unexpected word angle=%h origin=%b",
                                      rsp_data.angle, rsp_data.at_origin));
         end else begin
            want = pending_bearings.pop_front();
            if (rsp_data.angle !== want.angle)
               report_mismatch($sformatf("angle %h, expected %h",
                                         rsp_data.angle, want.angle));
            if (rsp_data.at_origin !== want.at_origin)
               report_mismatch($sformatf("at_origin %b, expected %b",
                                         rsp_data.at_origin, want.at_origin));
         end
      end
   end

   // Response side: runs of ready, broken by random stalls
   initial begin
      int hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(negedge clock);
         else repeat ($urandom_range(1, 4)) @(negedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
      end
   end

   // Request side: directed table, random vectors, then drain
   initial begin
      req_type word;
      rsp_type answer;
      int      burst_left;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      bearing_errors = 0;
      burst_left     = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (probe_table[i]) begin
         word.y_coord     = probe_table[i].y;
         word.x_coord     = probe_table[i].x;
         answer.angle     = probe_table[i].angle;
         answer.at_origin = probe_table[i].origin;
         send_word(word, probe_table[i].typed, answer);
         idle_source(burst_left);
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         send_word(random_word(), 1'b0, '0);
         idle_source(burst_left);
      end
      req_valid <= 1'b0;

      // wait out the pipeline, then a margin for stray words
      while (pending_bearings.size() != 0) @(posedge clock);
      repeat (4 * (CELLS + 2)) @(posedge clock);
      if (bearing_errors == 0) begin
         $display("full_circle_arctangent_unit regression: pass");
      end else begin
         $display("full_circle_arctangent_unit regression: fail");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #4ms;
      $display("full_circle_arctangent_unit regression: fail");
      $finish;
   end

endmodule
